// ===== hw/rtl/v4lc_pkg.sv =====
//------------------------------------------------------------------------------
// v4lc_pkg: shared types and constants for the vector length clamp
// Holds the field widths, stage sizes and the beat type passed between stages.
//------------------------------------------------------------------------------
`default_nettype none

package v4lc_pkg;

    localparam int CompW   = 32;
    localparam int NComp   = 4;
    localparam int SumW    = 66;   // sum of four squares of 32-bit magnitudes
    localparam int LenW    = 33;   // length up to 2^32
    localparam int SqrtN   = 33;   // one result bit per root stage
    localparam int ProdW   = 65;   // magnitude (32) times clamped length (32)
    localparam int DivN    = 65;   // one quotient bit per divide stage
    localparam int RemW    = 34;   // partial remainder, below twice the length

    localparam logic [1:0] RegMin = 2'd0;
    localparam logic [1:0] RegMax = 2'd1;

    typedef logic [CompW-1:0] comp_t;
    typedef logic [LenW-1:0]  len_t;

    // Sideband carried along the divide pipeline
    typedef struct packed {
        logic [NComp-1:0] neg;
        len_t             len;
        logic             clamped;
    } v4lc_side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/v4lc_isqrt.sv =====
//------------------------------------------------------------------------------
// v4lc_isqrt: pipelined integer square root
// One result bit per stage, restoring form; carries a sideband alongside.
//------------------------------------------------------------------------------
`default_nettype none

module v4lc_isqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [v4lc_pkg::SumW-1:0]    radicand,
    input  wire logic [4*32+3:0]              side_in,
    output logic                              out_valid,
    output logic [v4lc_pkg::LenW-1:0]         root,
    output logic [4*32+3:0]                   side_out
);
    import v4lc_pkg::*;

    logic                      vld_reg  [1:SqrtN];
    logic [SumW-1:0]           rem_reg  [1:SqrtN];
    logic [LenW-1:0]           root_reg [1:SqrtN];
    logic [4*32+3:0]           side_reg [1:SqrtN];

    for (genvar s = 0; s < SqrtN; s++) begin : g_stage
        localparam int B = SqrtN - 1 - s;
        logic            vld_cur;
        logic [SumW-1:0] rem_cur;
        logic [LenW-1:0] root_cur;
        logic [4*32+3:0] side_cur;
        logic [SumW+1:0] trial;
        logic [SumW+1:0] sub;

        // first stage takes the inputs, later ones the previous registers
        if (s == 0) begin : g_head
            assign vld_cur  = in_valid;
            assign rem_cur  = radicand;
            assign root_cur = '0;
            assign side_cur = side_in;
        end
        else begin : g_tail
            assign vld_cur  = vld_reg[s];
            assign rem_cur  = rem_reg[s];
            assign root_cur = root_reg[s];
            assign side_cur = side_reg[s];
        end

        always_comb
        begin
            // candidate (2*root + 2^B) * 2^B
            trial = ({{(SumW+2-LenW){1'b0}}, root_cur} << (B + 1))
                  | ({{(SumW+1){1'b0}}, 1'b1} << (2 * B));
            sub   = {2'b00, rem_cur} - trial;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_cur;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s+1] <= side_cur;
                if (!sub[SumW+1] && trial <= {2'b00, rem_cur})
                begin
                    rem_reg[s+1]  <= sub[SumW-1:0];
                    root_reg[s+1] <= root_cur | (LenW'(1) << B);
                end
                else
                begin
                    rem_reg[s+1]  <= rem_cur;
                    root_reg[s+1] <= root_cur;
                end
            end
        end
    end

    assign out_valid = vld_reg[SqrtN];
    assign root      = root_reg[SqrtN];
    assign side_out  = side_reg[SqrtN];

`ifndef SYNTHESIS
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> root <= 33'h1_0000_0000)
        else $error("root above 2^32");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/v4lc_div.sv =====
//------------------------------------------------------------------------------
// v4lc_div: pipelined restoring divider, four lanes sharing one divisor
// One quotient bit per stage per lane, then saturation to signed 32 bits.
//------------------------------------------------------------------------------
`default_nettype none

module v4lc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [v4lc_pkg::ProdW-1:0]  dividend [v4lc_pkg::NComp],
    input  wire v4lc_pkg::v4lc_side_t        side_in,
    output logic                             out_valid,
    output logic [v4lc_pkg::CompW-1:0]       result [v4lc_pkg::NComp],
    output v4lc_pkg::v4lc_side_t             side_out
);
    import v4lc_pkg::*;

    logic             vld_reg  [1:DivN];
    v4lc_side_t       side_reg [1:DivN];
    logic [ProdW-1:0] num_reg [1:DivN][NComp];
    logic [RemW-1:0]  rem_reg [1:DivN][NComp];
    logic [ProdW-1:0] quo_reg [1:DivN][NComp];

    for (genvar s = 0; s < DivN; s++) begin : g_stage
        logic       vld_cur;
        v4lc_side_t side_cur;

        // first stage takes the inputs, later ones the previous registers
        if (s == 0) begin : g_head
            assign vld_cur  = in_valid;
            assign side_cur = side_in;
        end
        else begin : g_tail
            assign vld_cur  = vld_reg[s];
            assign side_cur = side_reg[s];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_cur;
        end
        for (genvar l = 0; l < NComp; l++) begin : g_lane
            logic [ProdW-1:0] num_cur;
            logic [RemW-1:0]  rem_cur;
            logic [ProdW-1:0] quo_cur;
            logic [RemW-1:0]  sh;
            logic [RemW:0]    df;

            if (s == 0) begin : g_head
                assign num_cur = dividend[l];
                assign rem_cur = '0;
                assign quo_cur = '0;
            end
            else begin : g_tail
                assign num_cur = num_reg[s][l];
                assign rem_cur = rem_reg[s][l];
                assign quo_cur = quo_reg[s][l];
            end

            always_comb
            begin
                sh = {rem_cur[RemW-2:0], num_cur[ProdW-1]};
                df = {1'b0, sh} - {2'b00, side_cur.len};
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s+1][l] <= num_cur << 1;
                    if (!df[RemW])
                    begin
                        rem_reg[s+1][l] <= df[RemW-1:0];
                        quo_reg[s+1][l] <= {quo_cur[ProdW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s+1][l] <= sh;
                        quo_reg[s+1][l] <= {quo_cur[ProdW-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[s+1] <= side_cur;
        end
    end

    // saturate and apply sign; zero length gives zero
    always_comb
    begin
        logic [ProdW-1:0] q;
        for (int l = 0; l < NComp; l++)
        begin
            q = quo_reg[DivN][l];
            if (side_reg[DivN].len == '0)
                result[l] = '0;
            else if (side_reg[DivN].neg[l])
                result[l] = (q > 65'h8000_0000) ? 32'h8000_0000 : CompW'(-q);
            else
                result[l] = (q > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[CompW-1:0];
        end
    end

    assign out_valid = vld_reg[DivN];
    assign side_out  = side_reg[DivN];

`ifndef SYNTHESIS
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side_out.len == '0 |-> result[0] == '0 && result[3] == '0)
        else $error("zero length with nonzero output");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/vector4_length_clamp_top.sv =====
//------------------------------------------------------------------------------
// vector4_length_clamp_top: clamp the Euclidean length of a Q16.16 4-vector
// Squares, root, clamp, multiply and divide in one deep pipeline.
//------------------------------------------------------------------------------
// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid/tready    tdata = comp_x, comp_y, comp_z, comp_w
// m_axis    out  tvalid/tready    tdata = out_x..out_w, orig_length, was_clamped
// cfg       in   cfg_we           cfg_index 0 min_length, 1 max_length
//
// One beat per cycle enters unless the pipe stalls; the path holds 3 front
// stages, 33 root stages, 1 clamp, 1 multiply, 65 divide, 1 output register.
// The root and divide chains set the depth: one result bit per stage.
// The whole pipe advances when the output register is empty or taken;
// a stall freezes every stage, so nothing drops or repeats.
// Reset clears valid bits and sets min_length to 0, max_length to all ones.
//------------------------------------------------------------------------------
`default_nettype none

module vector4_length_clamp_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // comp_x, comp_y, comp_z, comp_w
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [167:0]      m_axis_tdata,   // out_x..out_w, orig_length, was_clamped
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import v4lc_pkg::*;

    logic [31:0] min_reg, max_reg;
    logic        en;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '1;
        end
        else if (cfg_we)
        begin
            if ({1'b0, cfg_index} == RegMin)
                min_reg <= cfg_data;
            else
                max_reg <= cfg_data;
        end
    end

    // advance everything when the output slot frees up
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: magnitudes and signs
    logic              v1_reg;
    logic [31:0]       mag1_reg [NComp];
    logic [NComp-1:0]  neg1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < NComp; i++)
            begin
                neg1_reg[i] <= s_axis_tdata[32*i+31];
                mag1_reg[i] <= s_axis_tdata[32*i+31] ? 32'(-s_axis_tdata[32*i +: 32])
                                                     : s_axis_tdata[32*i +: 32];
            end
    end

    // stage 2: squares
    logic        v2_reg;
    logic [63:0] sq2_reg [NComp];
    logic [31:0] mag2_reg [NComp];
    logic [NComp-1:0] neg2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg <= neg1_reg;
            for (int i = 0; i < NComp; i++)
            begin
                sq2_reg[i]  <= 64'(mag1_reg[i]) * 64'(mag1_reg[i]);
                mag2_reg[i] <= mag1_reg[i];
            end
        end
    end

    // stage 3: sum of squares
    logic            v3_reg;
    logic [SumW-1:0] sum3_reg;
    logic [31:0]     mag3_reg [NComp];
    logic [NComp-1:0] neg3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg3_reg <= neg2_reg;
            mag3_reg <= mag2_reg;
            sum3_reg <= SumW'(sq2_reg[0]) + SumW'(sq2_reg[1])
                      + SumW'(sq2_reg[2]) + SumW'(sq2_reg[3]);
        end
    end

    // root pipeline, magnitudes and signs ride alongside
    logic [4*32+3:0] side_in, side_out;
    logic            v4;
    len_t            len4;
    always_comb
    begin
        side_in = {neg3_reg, mag3_reg[3], mag3_reg[2], mag3_reg[1], mag3_reg[0]};
    end

    v4lc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  (sum3_reg),
        .side_in   (side_in),
        .out_valid (v4),
        .root      (len4),
        .side_out  (side_out)
    );

    // stage: clamp
    logic        v5_reg;
    len_t        len5_reg;
    logic [31:0] c5_reg;
    logic        cl5_reg;
    logic [31:0] mag5_reg [NComp];
    logic [NComp-1:0] neg5_reg;
    len_t        c_max, c_fin;
    always_comb
    begin
        c_max = (len4 > {1'b0, max_reg}) ? {1'b0, max_reg} : len4;
        c_fin = (c_max < {1'b0, min_reg}) ? {1'b0, min_reg} : c_max;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len5_reg <= len4;
            c5_reg   <= c_fin[31:0];
            cl5_reg  <= c_fin != len4;
            neg5_reg <= side_out[131:128];
            for (int i = 0; i < NComp; i++)
                mag5_reg[i] <= side_out[32*i +: 32];
        end
    end

    // stage: products magnitude * clamped length
    logic        v6_reg;
    logic [ProdW-1:0] prod6_reg [NComp];
    v4lc_side_t  side6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side6_reg.neg     <= neg5_reg;
            side6_reg.len     <= len5_reg;
            side6_reg.clamped <= cl5_reg;
            for (int i = 0; i < NComp; i++)
                prod6_reg[i] <= ProdW'(64'(mag5_reg[i]) * 64'(c5_reg));
        end
    end

    logic        v7;
    comp_t       res7 [NComp];
    v4lc_side_t  side7;

    v4lc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .dividend  (prod6_reg),
        .side_in   (side6_reg),
        .out_valid (v7),
        .result    (res7),
        .side_out  (side7)
    );

    // output register
    logic [167:0] tdata_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (en)
            m_axis_tvalid <= v7;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            tdata_reg <= {7'b0, side7.clamped,
                          side7.len[32] ? 32'hFFFF_FFFF : side7.len[31:0],
                          res7[3], res7[2], res7[1], res7[0]};
    end
    assign m_axis_tdata = tdata_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready with empty output");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[167:161] == '0)
        else $error("pad bits set");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_vector4_length_clamp_top.sv =====
//------------------------------------------------------------------------------
// tb_vector4_length_clamp_top: self-checking bench for the vector length clamp
// Drives Q16.16 vectors through the stream ports, predicts the clamped and
// scaled vector, length and clamp flag per beat, and compares in order while
// both sides idle at random and the bounds step through several settings.
//------------------------------------------------------------------------------
`default_nettype none

class v4lc_scoreboard;
    typedef struct packed {
        logic [31:0] w, z, y, x;
        logic [31:0] olen;
        logic        clamped;
    } clamp_result_t;

    clamp_result_t pending[$];
    logic [31:0]   lo_bound;
    logic [31:0]   hi_bound;
    int            errors;

    function new();
        lo_bound = 32'd0;
        hi_bound = 32'hFFFF_FFFF;
        errors   = 0;
    endfunction

    // Scale one component magnitude by c/len, truncate, saturate, restore sign.
    function logic [31:0] scale(logic [31:0] comp, logic [32:0] c, logic [32:0] len);
        logic        neg;
        logic [32:0] mag;
        logic [95:0] q;
        neg = comp[31];
        mag = neg ? (33'h1_0000_0000 - {1'b0, comp}) : {1'b0, comp};
        if (len == 0)
            return 32'd0;
        q = ({63'd0, mag} * {63'd0, c}) / {63'd0, len};
        if (neg)
        begin
            if (q > 96'h8000_0000)
                q = 96'h8000_0000;
            return 32'(33'h1_0000_0000 - q[32:0]);
        end
        if (q > 96'h7FFF_FFFF)
            q = 96'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function void note_vector(logic [127:0] v);
        logic [32:0]   mag;
        logic [65:0]   sum;
        logic [32:0]   len;
        logic [32:0]   c;
        logic [32:0]   t;
        clamp_result_t r;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag = v[i*32+31] ? (33'h1_0000_0000 - {1'b0, v[i*32 +: 32]})
                             : {1'b0, v[i*32 +: 32]};
            sum += {33'd0, mag} * {33'd0, mag};
        end
        // bitwise integer root, one bit per step
        len = 0;
        for (int b = 32; b >= 0; b--)
        begin
            t = len | (33'd1 << b);
            if ({33'd0, t} * {33'd0, t} <= {66'd0, sum})
                len = t;
        end
        c = len;
        if (c > {1'b0, hi_bound})
            c = {1'b0, hi_bound};
        if (c < {1'b0, lo_bound})
            c = {1'b0, lo_bound};
        r.x = scale(v[31:0], c, len);
        r.y = scale(v[63:32], c, len);
        r.z = scale(v[95:64], c, len);
        r.w = scale(v[127:96], c, len);
        r.olen = len[32] ? 32'hFFFF_FFFF : len[31:0];
        r.clamped = (c != len);
        pending.push_back(r);
    endfunction

    function void check_result(logic [167:0] d);
        clamp_result_t e;
        logic [31:0]   got[6];
        logic [31:0]   want[6];
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result beat %h", $time, d);
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int i = 0; i < 5; i++)
            got[i] = d[i*32 +: 32];
        got[5] = {31'd0, d[160]};
        want = '{e.x, e.y, e.z, e.w, e.olen, {31'd0, e.clamped}};
        for (int i = 0; i < 6; i++)
            if (got[i] !== want[i])
            begin
                $display("%0t: field %0d expected %h actual %h", $time, i, want[i], got[i]);
                errors++;
            end
        if (d[167:161] !== 7'd0)
        begin
            $display("%0t: pad bits expected 0 actual %h", $time, d[167:161]);
            errors++;
        end
    endfunction
endclass

module tb_vector4_length_clamp_top;
    import v4lc_pkg::*;

    localparam int LATENCY = 104;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    v4lc_scoreboard board = new();
    bit             no_idle = 1'b0;   // last part of the run: no gaps on either side

    vector4_length_clamp_top u_top (.*);

    always #2 clk = ~clk;

    // Hard limit: ~1100 beats with worst gaps and stalls stay far below this.
    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // Take result beats at the rising edge; stall in random bursts.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    // Write one bound; only called while the pipe is empty.
    task automatic write_bound(logic [0:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == RegMin[0])
            board.lo_bound = value;
        else
            board.hi_bound = value;
    endtask

    // Hold the beat until it is taken; leaves time at a falling edge with
    // tvalid still high, so the next beat can follow without a gap.
    task automatic send_vector(logic [127:0] v);
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        board.note_vector(v);
        @(negedge clk);
    endtask

    // Drop tvalid and wait out every pending result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
            3:       return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 4 << 16);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [127:0] v;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats at reset bounds: zero, extremes, all -2^31, unit axes.
        send_vector('0);
        send_vector({4{32'h8000_0000}});
        send_vector({4{32'h7FFF_FFFF}});
        send_vector({96'd0, 32'h0001_0000});
        send_vector({32'hFFFF_0000, 96'd0});
        send_vector({32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF});
        send_vector({4{32'h5555_AAAA}});
        drain();

        // Normalize; then min above max; also pushes scaled overflow.
        write_bound(RegMin[0], 32'h0001_0000);
        write_bound(RegMax[0], 32'h0001_0000);
        send_vector('0);
        send_vector({96'd0, 32'h0003_0000});
        send_vector({4{32'h8000_0000}});
        send_vector({32'd0, 32'd0, 32'd1, 32'd0});
        drain();
        write_bound(RegMin[0], 32'hFFFF_FFFF);
        write_bound(RegMax[0], 32'd0);
        send_vector({96'd0, 32'h7FFF_FFFF});
        send_vector({96'd0, 32'h0000_0001});
        send_vector({4{32'h8000_0000}});
        send_vector('0);
        drain();

        // Random phases, each with fresh bounds; pausing between phases
        // lets the sender wait out every pending result.
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 9)
                no_idle = 1'b1;
            write_bound(RegMin[0], rand_bound());
            write_bound(RegMax[0], rand_bound());
            for (int n = 0; n < 100; n++)
            begin
                v = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
                send_vector(v);
            end
            drain();
        end

        repeat (LATENCY + 20) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
